// File: src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge, off while reset is held.
`define BPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bitmap allocator check failed");
// Check an implication on every rising clock edge, off while reset is held.
`define BPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap allocator implication failed");
`else
`define BPA_ASSERT(lbl, prop)
`define BPA_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// File: src/bpa_pkg.sv
// Types and constants of the bitmap page allocator.
package bpa_pkg;

  localparam int AddrW = 48;
  localparam int CntW  = 20;
  localparam int PgW   = 13;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_MARK    = 3'd1,
    CMD_RESERVE = 3'd2,
    CMD_ALLOC   = 3'd3,
    CMD_RELEASE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_MARK,
    OP_RESERVE,
    OP_REL_CHECK,
    OP_REL_WRITE,
    OP_ALLOC_SCAN,
    OP_ALLOC_WRITE
  } op_t;

endpackage

// File: src/bpa_if.sv
// Request and result channel interfaces of the bitmap page allocator.
interface bpa_req_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [AddrW-1:0]  address;
  logic [CntW-1:0]   count;
  logic [AddrW-1:0]  size_bytes;
  modport source (output valid, cmd, address, count, size_bytes, input ready);
  modport sink   (input valid, cmd, address, count, size_bytes, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [AddrW-1:0]  run_address;
  logic [PgW-1:0]    free_pages;
  logic [PgW-1:0]    managed_pages;
  modport source (output valid, ok, run_address, free_pages, managed_pages, input ready);
  modport sink   (input valid, ok, run_address, free_pages, managed_pages, output ready);
endinterface

// File: src/bitmap_page_allocator_unit.sv
// Top level of the first-fit bitmap page-frame allocator.
//
//   channel   dir  handshake      contents
//   in_req    in   valid/ready    cmd, address, count, size_bytes
//   out_rsp   out  valid/ready    ok, run_address, free_pages, managed_pages
//   cfg_*     in   write enable   pages_in_use (13 bits)
//
// Each page frame holds {usable, busy} in one 2-bit memory with a registered read
// port; each valid command is a sweep of read-modify-write over a frame range.
// Mark usable and reserve sweep their range once, release twice (check, then
// write), allocate scans up to lim then writes the run, clear sweeps every frame,
// all bound by the memory port. After reset a clearing pass runs with in_req.ready low.
// A request is taken while an earlier result still waits on out_rsp.
`include "assert_macros.svh"
module bitmap_page_allocator_unit import bpa_pkg::*; #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [PgW-1:0]  cfg_wdata,
  bpa_req_if.sink         in_req,
  bpa_rsp_if.source       out_rsp
);

  localparam int FW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int LW = $clog2(MAX_PAGES + 1);

  // frame map: bit 1 usable, bit 0 busy
  logic [1:0] map_mem [MAX_PAGES];
  logic [1:0] rd_data_r;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic             boot_r, boot_nxt;
  logic [PgW-1:0]   pages_in_use_r;
  logic [PgW-1:0]   free_r, free_nxt;
  logic [PgW-1:0]   managed_r, managed_nxt;

  // held request
  logic [2:0]       cmd_r;
  logic [AddrW-1:0] addr_r;
  logic [CntW-1:0]  cnt_r;
  logic [AddrW-1:0] size_r;

  // sweep engine
  logic [LW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    lo_r, lo_nxt;
  logic [LW-1:0]    hi_r, hi_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic [LW-1:0]    s1_idx_r, s1_idx_nxt;
  logic [LW-1:0]    run_len_r, run_len_nxt;
  logic [LW-1:0]    run_start_r, run_start_nxt;
  logic             fail_r, fail_nxt;

  // result
  logic             res_ok_r, res_ok_nxt;
  logic [AddrW-1:0] res_addr_r, res_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [AddrW-1:0] out_addr_r, out_addr_nxt;
  logic [PgW-1:0]   out_free_r, out_free_nxt;
  logic [PgW-1:0]   out_managed_r, out_managed_nxt;

  logic             rd_en;
  logic             mem_we;
  logic [1:0]       mem_wd;

  // decode helpers
  logic [LW-1:0]    lim;
  logic [AddrW-1:0] first_w;
  logic             first_in;
  logic [LW-1:0]    first_l;
  logic [LW-1:0]    rem;
  logic [LW-1:0]    mark_hi;
  logic [63:0]      lim_bytes;
  logic [AddrW:0]   range_top;
  logic [AddrW:0]   end_frame;
  logic [LW-1:0]    rsv_hi;
  logic             rel_pre_ok;
  logic             alloc_pre_ok;
  logic             u_bit, b_bit;
  logic [LW-1:0]    len_inc;

  always_comb begin
    if (32'(pages_in_use_r) >= 32'(MAX_PAGES)) begin
      lim = LW'(MAX_PAGES);
    end else begin
      lim = LW'(pages_in_use_r);
    end
    first_w   = addr_r >> PAGE_SHIFT;
    first_in  = first_w < AddrW'(lim);
    first_l   = first_w[LW-1:0];
    rem       = lim - first_l;
    if (32'(cnt_r) > 32'(rem)) begin
      mark_hi = lim;
    end else begin
      mark_hi = first_l + LW'(cnt_r);
    end
    lim_bytes = 64'(lim) << PAGE_SHIFT;
    range_top = (AddrW + 1)'(addr_r) + (AddrW + 1)'(size_r) - (AddrW + 1)'(1);
    end_frame = (range_top >> PAGE_SHIFT) + (AddrW + 1)'(1);
    if (end_frame > (AddrW + 1)'(lim)) begin
      rsv_hi = lim;
    end else begin
      rsv_hi = LW'(end_frame);
    end
    rel_pre_ok = (addr_r[PAGE_SHIFT-1:0] == '0) && (cnt_r != '0) && first_in &&
                 (32'(cnt_r) <= 32'(rem));
    alloc_pre_ok = (cnt_r != '0) && (32'(cnt_r) <= 32'(free_r));
  end

  assign u_bit   = rd_data_r[1];
  assign b_bit   = rd_data_r[0];
  assign len_inc = run_len_r + LW'(1);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    boot_nxt        = boot_r;
    free_nxt        = free_r;
    managed_nxt     = managed_r;
    rd_ptr_nxt      = rd_ptr_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    s1_v_nxt        = 1'b0;
    s1_idx_nxt      = rd_ptr_r;
    run_len_nxt     = run_len_r;
    run_start_nxt   = run_start_r;
    fail_nxt        = fail_r;
    res_ok_nxt      = res_ok_r;
    res_addr_nxt    = res_addr_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_ok_nxt      = out_ok_r;
    out_addr_nxt    = out_addr_r;
    out_free_nxt    = out_free_r;
    out_managed_nxt = out_managed_r;
    rd_en           = 1'b0;
    mem_we          = 1'b0;
    mem_wd          = 2'b01;

    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_ok_nxt   = 1'b1;
        res_addr_nxt = '0;
        rd_ptr_nxt   = '0;
        lo_nxt       = '0;
        hi_nxt       = '0;
        run_len_nxt  = '0;
        fail_nxt     = 1'b0;
        state_nxt    = ST_SWEEP;
        case (cmd_r)
          CMD_CLEAR: begin
            op_nxt      = OP_CLEAR;
            hi_nxt      = LW'(MAX_PAGES);
            free_nxt    = '0;
            managed_nxt = '0;
          end
          CMD_MARK: begin
            op_nxt = OP_MARK;
            if (first_in) begin
              rd_ptr_nxt = first_l;
              hi_nxt     = mark_hi;
            end
          end
          CMD_RESERVE: begin
            op_nxt = OP_RESERVE;
            if (size_r != '0 && 64'(addr_r) < lim_bytes) begin
              rd_ptr_nxt = first_l;
              hi_nxt     = rsv_hi;
            end
          end
          CMD_ALLOC: begin
            op_nxt = OP_ALLOC_SCAN;
            if (alloc_pre_ok) begin
              hi_nxt = lim;
            end else begin
              res_ok_nxt = 1'b0;
              state_nxt  = ST_DONE;
            end
          end
          CMD_RELEASE: begin
            op_nxt = OP_REL_CHECK;
            if (rel_pre_ok) begin
              rd_ptr_nxt = first_l;
              lo_nxt     = first_l;
              hi_nxt     = first_l + LW'(cnt_r);
            end else begin
              res_ok_nxt = 1'b0;
              state_nxt  = ST_DONE;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_SWEEP: begin
        // issue stage: read the next frame of the range
        if (rd_ptr_r != hi_r) begin
          rd_en      = 1'b1;
          rd_ptr_nxt = rd_ptr_r + LW'(1);
          s1_v_nxt   = 1'b1;
        end
        // data stage: modify and write back the frame read last cycle
        if (s1_v_r) begin
          case (op_r)
            OP_CLEAR: begin
              mem_we = 1'b1;
              mem_wd = 2'b01;
            end
            OP_MARK: begin
              if (!u_bit) begin
                mem_we      = 1'b1;
                mem_wd      = 2'b10;
                managed_nxt = managed_r + PgW'(1);
                free_nxt    = free_r + PgW'(1);
              end
            end
            OP_RESERVE: begin
              if (u_bit) begin
                mem_we = 1'b1;
                mem_wd = 2'b01;
                if (!b_bit && free_r != '0) begin
                  free_nxt = free_r - PgW'(1);
                end
                if (managed_r != '0) begin
                  managed_nxt = managed_r - PgW'(1);
                end
              end
            end
            OP_REL_CHECK: begin
              if (!(u_bit && b_bit)) begin
                fail_nxt = 1'b1;
              end
            end
            OP_REL_WRITE: begin
              mem_we = 1'b1;
              mem_wd = 2'b10;
            end
            OP_ALLOC_SCAN: begin
              if (u_bit && !b_bit) begin
                if (run_len_r == '0) begin
                  run_start_nxt = s1_idx_r;
                end
                run_len_nxt = len_inc;
                if (32'(len_inc) == 32'(cnt_r)) begin
                  // run found: drop the read in flight, write the run busy
                  s1_v_nxt = 1'b0;
                  op_nxt   = OP_ALLOC_WRITE;
                  if (run_len_r == '0) begin
                    rd_ptr_nxt = s1_idx_r;
                    hi_nxt     = s1_idx_r + LW'(cnt_r);
                    res_addr_nxt = AddrW'(s1_idx_r) << PAGE_SHIFT;
                  end else begin
                    rd_ptr_nxt = run_start_r;
                    hi_nxt     = run_start_r + LW'(cnt_r);
                    res_addr_nxt = AddrW'(run_start_r) << PAGE_SHIFT;
                  end
                  free_nxt = free_r - PgW'(cnt_r);
                end
              end else begin
                run_len_nxt = '0;
              end
            end
            OP_ALLOC_WRITE: begin
              mem_we = 1'b1;
              mem_wd = 2'b11;
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end
        // end of range: all reads issued and the last one handled
        if (rd_ptr_r == hi_r && !s1_v_r) begin
          state_nxt = ST_DONE;
          case (op_r)
            OP_CLEAR: begin
              if (boot_r) begin
                boot_nxt  = 1'b0;
                state_nxt = ST_IDLE;
              end
            end
            OP_REL_CHECK: begin
              if (fail_r) begin
                res_ok_nxt = 1'b0;
              end else begin
                op_nxt     = OP_REL_WRITE;
                rd_ptr_nxt = lo_r;
                state_nxt  = ST_SWEEP;
              end
            end
            OP_REL_WRITE: begin
              free_nxt = free_r + PgW'(cnt_r);
            end
            OP_ALLOC_SCAN: begin
              res_ok_nxt = 1'b0;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt   = 1'b1;
          out_ok_nxt      = res_ok_r;
          out_addr_nxt    = res_addr_r;
          out_free_nxt    = free_r;
          out_managed_nxt = managed_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_req.ready          = (state_r == ST_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.ok            = out_ok_r;
  assign out_rsp.run_address   = out_addr_r;
  assign out_rsp.free_pages    = out_free_r;
  assign out_rsp.managed_pages = out_managed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_SWEEP;
      op_r           <= OP_CLEAR;
      boot_r         <= 1'b1;
      pages_in_use_r <= '0;
      free_r         <= '0;
      managed_r      <= '0;
      rd_ptr_r       <= '0;
      hi_r           <= LW'(MAX_PAGES);
      s1_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      fail_r         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      boot_r      <= boot_nxt;
      free_r      <= free_nxt;
      managed_r   <= managed_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      hi_r        <= hi_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      fail_r      <= fail_nxt;
      if (cfg_we) begin
        pages_in_use_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r          <= lo_nxt;
    s1_idx_r      <= s1_idx_nxt;
    run_len_r     <= run_len_nxt;
    run_start_r   <= run_start_nxt;
    res_ok_r      <= res_ok_nxt;
    res_addr_r    <= res_addr_nxt;
    out_ok_r      <= out_ok_nxt;
    out_addr_r    <= out_addr_nxt;
    out_free_r    <= out_free_nxt;
    out_managed_r <= out_managed_nxt;
    if (in_req.valid && in_req.ready) begin
      cmd_r  <= in_req.cmd;
      addr_r <= in_req.address;
      cnt_r  <= in_req.count;
      size_r <= in_req.size_bytes;
    end
  end

  // frame map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[s1_idx_r[FW-1:0]] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= map_mem[rd_ptr_r[FW-1:0]];
    end
  end

  `BPA_ASSERT(a_free_le_managed, free_r <= managed_r)
  `BPA_ASSERT_IMP(a_write_from_stage, mem_we, s1_v_r && state_r == ST_SWEEP)
  `BPA_ASSERT_IMP(a_idle_no_stage, state_r == ST_IDLE, !s1_v_r)
  `BPA_ASSERT_IMP(a_ptr_in_range, state_r == ST_SWEEP, rd_ptr_r <= hi_r)

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the bitmap page-frame allocator.
module testbench;
  import bpa_pkg::*;

  localparam int NUM_FRAMES  = 4096;
  localparam int FRAME_SHIFT = 12;
  localparam int WATCHDOG_CYCLES = 60000;
  localparam logic [2:0] CMD_UNDEF = 3'd5;

  typedef struct {
    logic [2:0]       cmd;
    logic [AddrW-1:0] address;
    logic [CntW-1:0]  count;
    logic [AddrW-1:0] size_bytes;
  } page_req_t;

  typedef struct {
    logic             ok;
    logic [AddrW-1:0] run_address;
    logic [PgW-1:0]   free_pages;
    logic [PgW-1:0]   managed_pages;
  } page_rsp_t;

  // One directed row; typed rows carry their own expected response.
  typedef struct {
    page_req_t req;
    bit        typed;
    page_rsp_t rsp;
  } directed_row_t;

  // A held run returned by a successful allocate, used to build good releases.
  typedef struct {
    int unsigned first;
    int unsigned len;
  } held_run_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PgW-1:0] cfg_wdata;

  bpa_req_if req_ch();
  bpa_rsp_if rsp_ch();

  bitmap_page_allocator_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_ch),
    .out_rsp  (rsp_ch)
  );

  // Shadow allocator state.
  bit          usable_frame [NUM_FRAMES];
  bit          busy_frame [NUM_FRAMES];
  int unsigned managed_frames;
  int unsigned free_frames;
  logic [PgW-1:0] pages_cfg;

  page_rsp_t     pending_rsp_q[$];
  held_run_t     held_runs[$];
  directed_row_t directed_rows[$];

  int  mismatch_count;
  int  idle_cycles;
  bit  rsp_stall_off;
  bit  req_stall_off;

  // Free-running clock, period 12.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned frame_limit();
    return (pages_cfg < NUM_FRAMES) ? pages_cfg : NUM_FRAMES;
  endfunction

  function automatic void wipe_shadow();
    for (int p = 0; p < NUM_FRAMES; p++) begin
      usable_frame[p] = 1'b0;
      busy_frame[p]   = 1'b1;
    end
    managed_frames = 0;
    free_frames    = 0;
    held_runs.delete();
  endfunction

  // Predict one response and advance the shadow maps.
  function automatic page_rsp_t model_page_command(page_req_t r);
    page_rsp_t   rsp;
    longint unsigned lim, first, cnt, stop, base, len, start, run_len;
    bit          fail;
    held_run_t   h;
    lim = frame_limit();
    rsp.ok = 1'b1;
    rsp.run_address = '0;
    case (r.cmd)
      CMD_CLEAR: wipe_shadow();
      CMD_MARK: begin
        first = r.address >> FRAME_SHIFT;
        cnt = r.count;
        if (first < lim) begin
          if (cnt > lim - first) cnt = lim - first;
          for (longint unsigned p = first; p < first + cnt; p++) begin
            if (!usable_frame[p]) begin
              usable_frame[p] = 1'b1;
              busy_frame[p]   = 1'b0;
              managed_frames++;
              free_frames++;
            end
          end
        end
      end
      CMD_RESERVE: begin
        base = r.address;
        len  = r.size_bytes;
        if (len != 0 && base < (lim << FRAME_SHIFT)) begin
          start = base >> FRAME_SHIFT;
          stop  = ((base + len - 1) >> FRAME_SHIFT) + 1;
          if (stop > lim) stop = lim;
          for (longint unsigned p = start; p < stop; p++) begin
            if (usable_frame[p]) begin
              usable_frame[p] = 1'b0;
              if (!busy_frame[p] && free_frames > 0) free_frames--;
              busy_frame[p] = 1'b1;
              if (managed_frames > 0) managed_frames--;
            end
          end
        end
      end
      CMD_ALLOC: begin
        cnt = r.count;
        rsp.ok = 1'b0;
        if (cnt != 0 && cnt <= free_frames) begin
          run_len = 0;
          start = 0;
          for (longint unsigned p = 0; p < lim && !rsp.ok; p++) begin
            if (usable_frame[p] && !busy_frame[p]) begin
              if (run_len == 0) start = p;
              run_len++;
              if (run_len == cnt) begin
                for (longint unsigned q = start; q < start + cnt; q++) busy_frame[q] = 1'b1;
                free_frames = free_frames - 32'(cnt);
                rsp.ok = 1'b1;
                rsp.run_address = AddrW'(start << FRAME_SHIFT);
                h.first = 32'(start);
                h.len = 32'(cnt);
                held_runs.push_back(h);
              end
            end else begin
              run_len = 0;
            end
          end
        end
      end
      CMD_RELEASE: begin
        first = r.address >> FRAME_SHIFT;
        cnt = r.count;
        fail = (r.address[FRAME_SHIFT-1:0] != 0) || cnt == 0 || first >= lim ||
               cnt > lim - first;
        if (!fail) begin
          for (longint unsigned p = first; p < first + cnt; p++)
            if (!usable_frame[p] || !busy_frame[p]) fail = 1'b1;
        end
        if (!fail) begin
          for (longint unsigned p = first; p < first + cnt; p++) busy_frame[p] = 1'b0;
          free_frames = free_frames + 32'(cnt);
        end
        rsp.ok = !fail;
      end
      default: ;
    endcase
    rsp.free_pages    = free_frames[PgW-1:0];
    rsp.managed_pages = managed_frames[PgW-1:0];
    return rsp;
  endfunction

  task automatic report_mismatch(string field, logic [AddrW-1:0] got, logic [AddrW-1:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $time);
  endtask

  // Drive one request after an optional gap; predict it when it is taken.
  task automatic issue_request(page_req_t r, bit typed, page_rsp_t typed_rsp);
    int gap;
    int roll;
    page_rsp_t predicted;
    roll = $urandom_range(0, 99);
    gap = req_stall_off ? 0 :
          (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= r.cmd;
    req_ch.address    <= r.address;
    req_ch.count      <= r.count;
    req_ch.size_bytes <= r.size_bytes;
    do @(posedge clk); while (!req_ch.ready);
    predicted = model_page_command(r);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  // Hold the request channel low until every pending response has drained.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_pages_cfg(logic [PgW-1:0] value);
    drain_responses();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    pages_cfg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [AddrW-1:0] rand48();
    return AddrW'({$urandom, $urandom});
  endfunction

  // Build one random request, mostly well-formed against the current shadow state.
  function automatic page_req_t pick_request();
    page_req_t   r;
    int unsigned lim, roll, idx, half;
    held_run_t   h;
    lim  = frame_limit();
    roll = $urandom_range(0, 99);
    r.cmd = CMD_CLEAR;
    r.address = '0;
    r.count = '0;
    r.size_bytes = '0;
    if (roll < 2) begin
      r.cmd = CMD_CLEAR;
    end else if (roll < 17) begin
      r.cmd = CMD_MARK;
      r.address = (AddrW'($urandom_range(0, lim + 2)) << FRAME_SHIFT) |
                  AddrW'($urandom_range(0, 4095));
      r.count = ($urandom_range(0, 9) == 0) ? CntW'($urandom) :
                CntW'($urandom_range(0, lim / 4 + 2));
    end else if (roll < 27) begin
      r.cmd = CMD_RESERVE;
      r.address = AddrW'($urandom_range(0, (lim + 1) * 4096));
      r.size_bytes = ($urandom_range(0, 9) == 0) ? rand48() :
                     AddrW'($urandom_range(0, 3 * 4096));
    end else if (roll < 57) begin
      r.cmd = CMD_ALLOC;
      half = free_frames / 2;
      r.count = ($urandom_range(0, 9) == 0) ? CntW'($urandom_range(0, free_frames + 2)) :
                CntW'($urandom_range(1, (half > 1) ? half : 1));
    end else if (roll < 82 && held_runs.size() != 0) begin
      r.cmd = CMD_RELEASE;
      idx = $urandom_range(0, held_runs.size() - 1);
      h = held_runs[idx];
      held_runs.delete(idx);
      r.address = AddrW'(h.first) << FRAME_SHIFT;
      r.count = CntW'(h.len);
    end else if (roll < 90) begin
      r.cmd = CMD_RELEASE;
      r.address = AddrW'($urandom_range(0, lim + 1)) << FRAME_SHIFT;
      if ($urandom_range(0, 7) == 0)
        r.address[FRAME_SHIFT-1:0] = FRAME_SHIFT'($urandom_range(1, 4095));
      r.count = CntW'($urandom_range(0, 4));
    end else begin
      // noise: any command code, full-width fields
      r.cmd = 3'($urandom_range(0, 7));
      r.address = rand48();
      r.count = CntW'($urandom);
      r.size_bytes = rand48();
    end
    return r;
  endfunction

  task automatic add_row(logic [2:0] cmd, logic [AddrW-1:0] addr, logic [CntW-1:0] cnt,
                         logic [AddrW-1:0] size, bit typed, logic ok,
                         logic [AddrW-1:0] run, logic [PgW-1:0] free_n,
                         logic [PgW-1:0] man_n);
    directed_row_t row;
    row.req.cmd = cmd;
    row.req.address = addr;
    row.req.count = cnt;
    row.req.size_bytes = size;
    row.typed = typed;
    row.rsp.ok = ok;
    row.rsp.run_address = run;
    row.rsp.free_pages = free_n;
    row.rsp.managed_pages = man_n;
    directed_rows.push_back(row);
  endtask

  // Response side: randomly stall ready and check every accepted response.
  always @(negedge clk) begin
    int roll;
    roll = $urandom_range(0, 999);
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall_off) begin
      rsp_ch.ready <= 1'b1;
    end else if (!rsp_ch.ready) begin
      rsp_ch.ready <= ($urandom_range(0, 99) < 35);
    end else begin
      rsp_ch.ready <= (roll >= 150);
    end
  end

  always @(posedge clk) begin
    page_rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        mismatch_count++;
        $display("MISMATCH unexpected response at %0t", $time);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_ch.ok !== want.ok) report_mismatch("ok", rsp_ch.ok, want.ok);
        if (rsp_ch.run_address !== want.run_address)
          report_mismatch("run_address", rsp_ch.run_address, want.run_address);
        if (rsp_ch.free_pages !== want.free_pages)
          report_mismatch("free_pages", rsp_ch.free_pages, want.free_pages);
        if (rsp_ch.managed_pages !== want.managed_pages)
          report_mismatch("managed_pages", rsp_ch.managed_pages, want.managed_pages);
      end
    end
  end

  // Watchdog: end the run after too long without any handshake.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("bitmap_page_allocator_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_cfg [8];
    int unsigned phase_len [8];
    page_rsp_t   unused_rsp;
    phase_cfg = '{1, 8, 64, 4096, 8191, 200, 0, 37};
    phase_len = '{60, 120, 300, 60, 40, 300, 40, 110};
    // Hold every input known and assert reset.
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_CLEAR;
    req_ch.address = '0;
    req_ch.count = '0;
    req_ch.size_bytes = '0;
    rsp_ch.ready = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    rsp_stall_off = 1'b0;
    req_stall_off = 1'b0;
    pages_cfg = '0;
    unused_rsp = '{default: '0};
    wipe_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, run against 16 managed frames.
    add_row(CMD_ALLOC,   0, 1, 0, 1, 0, 0, 0, 0);            // allocate from empty maps
    add_row(CMD_MARK,    0, 20'hFFFFF, 0, 1, 1, 0, 16, 16);  // clamp to the managed end
    add_row(CMD_ALLOC,   0, 0, 0, 1, 0, 0, 16, 16);          // zero count
    add_row(CMD_ALLOC,   0, 17, 0, 1, 0, 0, 16, 16);         // more than free
    add_row(CMD_ALLOC,   0, 1, 0, 1, 1, 0, 15, 16);          // frame zero is a success
    add_row(CMD_RELEASE, 1, 1, 0, 1, 0, 0, 15, 16);          // misaligned
    add_row(CMD_RELEASE, 0, 0, 0, 1, 0, 0, 15, 16);          // zero count
    add_row(CMD_RELEASE, 16 << 12, 1, 0, 1, 0, 0, 15, 16);   // first frame beyond end
    add_row(CMD_RELEASE, 15 << 12, 2, 0, 1, 0, 0, 15, 16);   // run passes the end
    add_row(CMD_RELEASE, 1 << 12, 1, 0, 1, 0, 0, 15, 16);    // frame not busy
    add_row(CMD_RELEASE, 0, 1, 0, 1, 1, 0, 16, 16);
    add_row(CMD_RESERVE, 0, 0, 0, 1, 1, 0, 16, 16);          // empty range
    add_row(CMD_RESERVE, 16 << 12, 0, 5, 1, 1, 0, 16, 16);   // base beyond managed bytes
    add_row(CMD_RESERVE, 48'h1FFF, 0, 2, 1, 1, 0, 14, 14);   // straddles frames 1 and 2
    add_row(CMD_RESERVE, {AddrW{1'b1}}, 0, {AddrW{1'b1}}, 1, 1, 0, 14, 14);
    add_row(CMD_ALLOC,   0, 14, 0, 1, 0, 0, 14, 14);         // no run long enough
    add_row(CMD_ALLOC,   0, 13, 0, 0, 0, 0, 0, 0);
    add_row(CMD_RESERVE, 10 << 12, 0, 8192, 0, 0, 0, 0, 0);  // reserve busy frames
    add_row(CMD_UNDEF,   0, 0, 0, 1, 1, 0, 1, 12);
    add_row(3'd7, {AddrW{1'b1}}, {CntW{1'b1}}, {AddrW{1'b1}}, 1, 1, 0, 1, 12);
    add_row(CMD_MARK, {AddrW{1'b1}}, 5, 0, 1, 1, 0, 1, 12); // start far beyond the end
    add_row(CMD_MARK, 0, 16, 0, 0, 0, 0, 0, 0);
    add_row(CMD_CLEAR,   0, 0, 0, 1, 1, 0, 0, 0);

    write_pages_cfg(13'd16);
    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    // Random phases over several frame limits, extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      write_pages_cfg(PgW'(phase_cfg[ph]));
      rsp_stall_off = (ph == 2);
      req_stall_off = (ph == 2) || (ph == 5);
      for (int n = 0; n < phase_len[ph]; n++) begin
        if (n == phase_len[ph] / 2) drain_responses();
        issue_request(pick_request(), 1'b0, unused_rsp);
      end
    end

    req_ch.valid <= 1'b0;
    rsp_stall_off = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("bitmap_page_allocator_unit verification clean");
    end else begin
      $display("bitmap_page_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
